[hdl/esd_pkg.sv]
// ----------------------------------------------------------------------------
// esd_pkg
// Types and constants shared by the event subscriber dispatch block.
// ----------------------------------------------------------------------------
`default_nettype none
package esd_pkg;

  localparam int unsigned ActW  = 3;
  localparam int unsigned EvW   = 16;
  localparam int unsigned CatW  = 8;
  localparam int unsigned IdW   = 31;
  localparam int unsigned StW   = 3;
  localparam int unsigned SlotW = 6;
  localparam int unsigned CntW  = 32;
  localparam int unsigned FillW = 7;
  localparam int unsigned NumCat = 16;

  typedef enum logic [ActW-1:0] {
    ACT_SUB_EVENT = 3'd0,
    ACT_SUB_CAT   = 3'd1,
    ACT_SUB_ALL   = 3'd2,
    ACT_UNSUB     = 3'd3,
    ACT_PUBLISH   = 3'd4
  } action_e;

  typedef enum logic [StW-1:0] {
    ST_SUBSCRIBED = 3'd0,
    ST_FULL       = 3'd1,
    ST_REMOVED    = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_DELIVERED  = 3'd4,
    ST_DROPPED    = 3'd5,
    ST_NONE       = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    MODE_UNUSED = 2'd0,
    MODE_EXACT  = 2'd1,
    MODE_CAT    = 2'd2,
    MODE_ALL    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [ActW-1:0] action;
    logic [EvW-1:0]  event_id;
    logic [CatW-1:0] category;
    logic [IdW-1:0]  unsub_id;
  } cmd_t;

endpackage
`default_nettype wire

[hdl/esd_front.sv]
// ----------------------------------------------------------------------------
// esd_front
// Accepts commands, drops unknown actions, and holds a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
module esd_front (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           start_i,
  input  esd_pkg::cmd_t cmd_i,
  output logic          busy_o,
  output logic          q_valid_o,
  output esd_pkg::cmd_t q_cmd_o,
  input  wire           q_pop_i
);
  import esd_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;

  assign busy_o    = (cnt_q == 2'd2);
  assign push      = start_i && !busy_o && (cmd_i.action <= ACT_PUBLISH);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end
endmodule
`default_nettype wire

[hdl/esd_back.sv]
// ----------------------------------------------------------------------------
// esd_back
// Slot table and sequencer: subscribe, unsubscribe, and publish scan.
// ----------------------------------------------------------------------------
`default_nettype none
module esd_back #(
  parameter int unsigned SLOTS         = 48,
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          q_valid_i,
  input  esd_pkg::cmd_t                q_cmd_i,
  output logic                         q_pop_o,
  output logic                         valid_o,
  output logic [esd_pkg::StW-1:0]      status_o,
  output logic [esd_pkg::IdW-1:0]      assigned_id_o,
  output logic [esd_pkg::SlotW-1:0]    slot_index_o,
  output logic                         last_of_run_o,
  output logic [esd_pkg::CntW-1:0]     published_count_o,
  output logic [esd_pkg::CntW-1:0]     dropped_count_o,
  output logic [esd_pkg::FillW-1:0]    history_fill_o
);
  import esd_pkg::*;

  localparam int unsigned HW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [HW-1:0] HMax = HW'(HISTORY_DEPTH);

  logic [1:0]     mode_q   [SLOTS];
  logic [EvW-1:0] filter_q [SLOTS];
  logic [IdW-1:0] id_q     [SLOTS];
  logic [IdW-1:0] next_id_q;
  logic [CntW-1:0] pub_q, drop_q;
  logic [HW-1:0]  hist_q;

  back_state_e    st_q, st_d;
  cmd_t           cmd_q;
  logic [SLOTS-1:0] mask_q;
  logic [SlotW-1:0] idx_q;
  logic           any_q;

  logic [SLOTS-1:0] cmask, amask, free_v, idm_v, hit_v;
  logic             free_any, idm_any;
  logic [SlotW-1:0] free_ix, idm_ix;
  logic [3:0]       pcat;

  assign pcat = q_cmd_i.event_id[11:8];

  always_comb begin
    cmask    = '0;
    amask    = '0;
    free_any = 1'b0;
    free_ix  = '0;
    idm_any  = 1'b0;
    idm_ix   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      free_v[i] = (mode_q[i] == MODE_UNUSED);
      idm_v[i]  = (mode_q[i] != MODE_UNUSED) && (id_q[i] == q_cmd_i.unsub_id)
                  && (q_cmd_i.unsub_id != '0);
      amask[i]  = (mode_q[i] == MODE_ALL);
      if (mode_q[i] == MODE_CAT)
        cmask[i] = (filter_q[i][7:0] == {4'd0, pcat});
      else if (mode_q[i] == MODE_EXACT)
        cmask[i] = (filter_q[i][15:8] == {4'd0, pcat});
      hit_v[i]  = (mode_q[i] == MODE_ALL) || (mode_q[i] == MODE_CAT) ||
                  ((mode_q[i] == MODE_EXACT) && (filter_q[i] == cmd_q.event_id));
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_v[i]) begin free_any = 1'b1; free_ix = SlotW'(i); end
      if (idm_v[i])  begin idm_any = 1'b1;  idm_ix = SlotW'(i);  end
    end
  end

  logic [SLOTS-1:0] rem, cur;
  logic             cur_hit, more;
  logic [SlotW-1:0] nidx;
  always_comb begin
    cur     = mask_q & hit_v;
    cur_hit = cur[idx_q[$clog2(SLOTS > 1 ? SLOTS : 2)-1:0]];
    rem     = '0;
    for (int i = 0; i < SLOTS; i++) rem[i] = cur[i] && (SlotW'(i) > idx_q);
    more    = |rem;
    nidx    = idx_q + SlotW'(1);
  end

  logic [IdW-1:0] nid_inc;
  assign nid_inc = next_id_q + IdW'(1);

  always_comb begin
    st_d    = st_q;
    q_pop_o = 1'b0;
    case (st_q)
      BK_IDLE: if (q_valid_i) begin
        q_pop_o = 1'b1;
        if (q_cmd_i.action == ACT_PUBLISH) st_d = BK_SCAN;
      end
      BK_SCAN: if (!more || idx_q == SlotW'(SLOTS - 1)) st_d = BK_IDLE;
      default: st_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= BK_IDLE;
      next_id_q <= IdW'(1);
      pub_q     <= '0;
      drop_q    <= '0;
      hist_q    <= '0;
      valid_o   <= 1'b0;
      for (int i = 0; i < SLOTS; i++) mode_q[i] <= MODE_UNUSED;
    end else begin
      st_q <= st_d;
      if (st_q == BK_IDLE && q_valid_i) begin
        valid_o <= (q_cmd_i.action != ACT_PUBLISH);
        if (q_cmd_i.action == ACT_PUBLISH) begin
          if (hist_q < HMax) hist_q <= hist_q + HW'(1);
          pub_q <= pub_q + CntW'(1);
          if ((cmask | amask) == '0) drop_q <= drop_q + CntW'(1);
        end else if (q_cmd_i.action == ACT_UNSUB) begin
          if (idm_any) mode_q[idm_ix] <= MODE_UNUSED;
        end else begin
          if (free_any) begin
            mode_q[free_ix] <= 2'(q_cmd_i.action) + 2'd1;
            filter_q[free_ix] <= (q_cmd_i.action == ACT_SUB_EVENT) ? q_cmd_i.event_id :
                                 (q_cmd_i.action == ACT_SUB_CAT) ?
                                 {8'd0, q_cmd_i.category} : '0;
            id_q[free_ix] <= next_id_q;
            next_id_q <= (nid_inc == '0) ? IdW'(1) : nid_inc;
          end
        end
      end else if (st_q == BK_SCAN) begin
        valid_o <= (mask_q == '0) || cur_hit || (!any_q && !more);
      end else begin
        valid_o <= 1'b0;
      end
    end
  end

  logic [FillW-1:0] fill;
  assign fill = (HW > FillW && hist_q > HW'(127)) ? FillW'(127) : FillW'(hist_q);

  always_ff @(posedge clk_i) begin
    history_fill_o    <= fill;
    published_count_o <= pub_q;
    dropped_count_o   <= drop_q;
    if (st_q == BK_IDLE && q_valid_i) begin
      cmd_q         <= q_cmd_i;
      mask_q        <= cmask | amask;
      idx_q         <= '0;
      any_q         <= 1'b0;
      last_of_run_o <= 1'b1;
      if (q_cmd_i.action == ACT_UNSUB) begin
        status_o      <= idm_any ? ST_REMOVED : ST_NOT_FOUND;
        assigned_id_o <= '0;
        slot_index_o  <= idm_any ? idm_ix : '0;
      end else if (free_any) begin
        status_o      <= ST_SUBSCRIBED;
        assigned_id_o <= next_id_q;
        slot_index_o  <= free_ix;
      end else begin
        status_o      <= ST_FULL;
        assigned_id_o <= '0;
        slot_index_o  <= '0;
      end
    end else if (st_q == BK_SCAN) begin
      idx_q         <= nidx;
      assigned_id_o <= '0;
      if (mask_q == '0) begin
        status_o <= ST_DROPPED; slot_index_o <= '0; last_of_run_o <= 1'b1;
      end else if (cur_hit) begin
        any_q <= 1'b1;
        status_o <= ST_DELIVERED; slot_index_o <= idx_q; last_of_run_o <= !more;
      end else begin
        status_o <= ST_NONE; slot_index_o <= '0; last_of_run_o <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

[hdl/event_subscriber_dispatch.sv]
// ----------------------------------------------------------------------------
// event_subscriber_dispatch
// Publish/subscribe dispatcher over a table of subscriber slots.
// ----------------------------------------------------------------------------
// Usage: drive a command on action_i and its fields with start_i high; it is
// taken when busy_o is low. A two-beat queue parts the command front from the
// table back end. Each result beat appears for one cycle with valid_o high.
// Subscribe and unsubscribe give one beat, registered when the back end pops
// the command from the queue; the back end stays idle. Publish latches the
// candidate mask, then a scan steps one slot per cycle from slot 0 and emits
// a beat for each match; it ends after the last match or at the last slot.
// An empty mask or no match gives a single beat. Actions 5..7 are dropped.
// Reset clears all slots, counters, the queue and sets the next id to 1.
// The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
`default_nettype none
module event_subscriber_dispatch #(
  parameter int unsigned SLOTS         = 48,
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          start_i,
  output logic                         busy_o,
  input  wire  [esd_pkg::ActW-1:0]     action_i,
  input  wire  [esd_pkg::EvW-1:0]      event_id_i,
  input  wire  [esd_pkg::CatW-1:0]     category_i,
  input  wire  [esd_pkg::IdW-1:0]      unsub_id_i,
  output logic                         valid_o,
  output logic [esd_pkg::StW-1:0]      status_o,
  output logic [esd_pkg::IdW-1:0]      assigned_id_o,
  output logic [esd_pkg::SlotW-1:0]    slot_index_o,
  output logic                         last_of_run_o,
  output logic [esd_pkg::CntW-1:0]     published_count_o,
  output logic [esd_pkg::CntW-1:0]     dropped_count_o,
  output logic [esd_pkg::FillW-1:0]    history_fill_o
);
  import esd_pkg::*;

  cmd_t cmd, q_cmd;
  logic q_valid, q_pop;

  assign cmd = '{action: action_i, event_id: event_id_i, category: category_i,
                 unsub_id: unsub_id_i};

  esd_front u_front (
    .clk_i, .rst_ni, .start_i, .cmd_i(cmd), .busy_o,
    .q_valid_o(q_valid), .q_cmd_o(q_cmd), .q_pop_i(q_pop)
  );

  esd_back #(.SLOTS(SLOTS), .HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_cmd_i(q_cmd), .q_pop_o(q_pop),
    .valid_o, .status_o, .assigned_id_o, .slot_index_o, .last_of_run_o,
    .published_count_o, .dropped_count_o, .history_fill_o
  );
endmodule
`default_nettype wire
